### rtl/adcr_pkg.sv
package adcr_pkg;

  // Reading and result formats
  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 8;
  localparam int REF_W     = 20;
  localparam int RANGE_W   = 2;
  localparam int NUM_RANGES = 1 << RANGE_W;
  localparam int STATUS_W  = 2;
  localparam int OUT_W     = 35;

  // Derived widths
  localparam int ADC_FS  = (1 << ADC_BITS) - 1;
  localparam int MUL_W   = ADC_BITS + 6;                 // adc * 50
  localparam int PROD_W  = REF_W + ADC_BITS;             // rref * adc
  localparam int DIVD_W  = PROD_W + FRAC_BITS + 1;       // dividend, one extra bit for rounding
  localparam int NCELL   = DIVD_W;                       // one quotient bit per cell
  localparam int QX_W    = (DIVD_W > OUT_W) ? DIVD_W : OUT_W;
  localparam int OFS_W   = 9;                            // band offsets up to 360 ohm
  localparam int OFS_SH_W = OFS_W + FRAC_BITS;

  // Rail thresholds on adc*50
  localparam logic [MUL_W-1:0] HIGH_LIM = MUL_W'(ADC_FS * 49);
  localparam logic [MUL_W-1:0] LOW_LIM  = MUL_W'(ADC_FS);

  // Saturation limit of the result
  localparam logic [QX_W-1:0] OUT_MAX = QX_W'((64'd1 << (OUT_W - 1)) - 64'd1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF3  = 3'd4;

  // Reference resistor reset values
  localparam logic [REF_W-1:0] REF0_RST = 20'd200;
  localparam logic [REF_W-1:0] REF1_RST = 20'd2000;
  localparam logic [REF_W-1:0] REF2_RST = 20'd20000;
  localparam logic [REF_W-1:0] REF3_RST = 20'd220000;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_HIGH = 2'd1,
    ST_LOW  = 2'd2
  } status_t;

  // Item in flight through the divider chain
  typedef struct packed {
    logic [ADC_BITS-1:0] rem;     // partial remainder
    logic [DIVD_W-1:0]   acc;     // dividend bits shifting out, quotient bits shifting in
    logic [ADC_BITS-1:0] den;     // divisor FS - adc
    status_t             status;
    logic [OFS_W-1:0]    offset;  // ohms to subtract, zero outside range 0
  } div_slot_t;

endpackage

### rtl/adcr_in_if.sv
interface adcr_in_if;
  logic                           valid;
  logic                           ready;
  logic [adcr_pkg::ADC_BITS-1:0]  adc_value;

  modport source (output valid, output adc_value, input ready);
  modport sink   (input valid, input adc_value, output ready);
endinterface

### rtl/adcr_out_if.sv
interface adcr_out_if;
  logic                               valid;
  logic                               ready;
  logic [adcr_pkg::STATUS_W-1:0]      status;
  logic signed [adcr_pkg::OUT_W-1:0]  resistance_q8;

  modport source (output valid, output status, output resistance_q8, input ready);
  modport sink   (input valid, input status, input resistance_q8, output ready);
endinterface

### rtl/adc_to_resistance_converter.sv
// Divider ohmmeter: turns one 12-bit reading of a resistor divider into the
// unknown resistance Rref*adc/(FS-adc) in signed ohms with 8 fraction bits.
// in_ch   : valid/ready channel carrying adc_value, one item per reading.
// out_ch  : valid/ready channel carrying status and resistance_q8, one item
//           per reading, in order. A nonzero status means the reading sat
//           too close to a rail; resistance_q8 is then zero.
// cfg_*   : write-only register port (range_select, four reference values),
//           to be written only while no item is in flight.
// Stages  : 43 register stages: one setup stage (rail check and rref*adc
//           product), 41 divider cells, one output stage.
// Rate    : one item per cycle unless out_ch stalls; the divider is a chain
//           of cells, each producing one quotient bit and passing it on.
// Stall   : each stage holds its item while the next one cannot take it; bubbles
//           close up, so in_ch.ready drops only once every stage is full.
// Reset   : synchronous, active low; empties the pipeline and loads the
//           default range 0 and reference values 200/2k/20k/220k ohm.
module adc_to_resistance_converter (
  input  logic                            clk,
  input  logic                            rst_n,
  adcr_in_if.sink                         in_ch,
  adcr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [adcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adcr_pkg::REF_W-1:0]      cfg_data
);
  import adcr_pkg::*;

  logic [RANGE_W-1:0] range_r;
  logic [REF_W-1:0]   ref_r [NUM_RANGES];

  logic               cell_v   [NCELL+1];
  logic               cell_rdy [NCELL+1];
  div_slot_t          cell_s   [NCELL+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r  <= '0;
      ref_r[0] <= REF0_RST;
      ref_r[1] <= REF1_RST;
      ref_r[2] <= REF2_RST;
      ref_r[3] <= REF3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE: range_r  <= cfg_data[RANGE_W-1:0];
        CFG_REF0:  ref_r[0] <= cfg_data;
        CFG_REF1:  ref_r[1] <= cfg_data;
        CFG_REF2:  ref_r[2] <= cfg_data;
        CFG_REF3:  ref_r[3] <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Setup stage
  adcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .adc      (in_ch.adc_value),
    .rref     (ref_r[range_r]),
    .range0   (range_r == '0),
    .dn_valid (cell_v[0]),
    .dn_ready (cell_rdy[0]),
    .dn_slot  (cell_s[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    adcr_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cell_v[i]),
      .up_ready (cell_rdy[i]),
      .up_slot  (cell_s[i]),
      .dn_valid (cell_v[i+1]),
      .dn_ready (cell_rdy[i+1]),
      .dn_slot  (cell_s[i+1])
    );
  end

  // Rounding, offset and output register
  adcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (cell_v[NCELL]),
    .up_ready  (cell_rdy[NCELL]),
    .up_slot   (cell_s[NCELL]),
    .dn_valid  (out_ch.valid),
    .dn_ready  (out_ch.ready),
    .dn_status (out_ch.status),
    .dn_res    (out_ch.resistance_q8)
  );

  // A flagged reading never carries a resistance
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |-> out_ch.resistance_q8 == '0)
    else $error("flagged result with nonzero resistance");

  // The last cell keeps its item while the output stage is blocked
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cell_v[NCELL] && !cell_rdy[NCELL] |=> cell_v[NCELL] && $stable(cell_s[NCELL]))
    else $error("last divider cell dropped a stalled item");

  // A blocked output with a full chain must stop the input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready && cell_v[0] && cell_v[NCELL] && !cell_rdy[0]
      |-> !in_ch.ready)
    else $error("input accepted into a blocked setup stage");

  // Output stage refills only when it can take an item
  a_back_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !cell_rdy[NCELL])
    else $error("output stage ready while holding a stalled result");

endmodule

### rtl/adcr_front.sv
module adcr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [adcr_pkg::ADC_BITS-1:0] adc,
  input  logic [adcr_pkg::REF_W-1:0]    rref,
  input  logic                          range0,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output adcr_pkg::div_slot_t           dn_slot
);
  import adcr_pkg::*;

  logic                valid_r;
  div_slot_t           slot_r;
  div_slot_t           slot_nxt;
  logic [MUL_W-1:0]    adc_x50;
  logic [PROD_W-1:0]   prod;
  logic [OFS_W-1:0]    band_ofs;

  // Calibration offset by reading band (range 0 only)
  always_comb begin
    priority if (32'(adc) < 2600) band_ofs = 9'd310;
    else if (32'(adc) < 2700)     band_ofs = 9'd330;
    else if (32'(adc) < 3005)     band_ofs = 9'd360;
    else if (32'(adc) < 3050)     band_ofs = 9'd300;
    else if (32'(adc) < 3100)     band_ofs = 9'd90;
    else                          band_ofs = '0;
  end

  // Rail check, product and divisor setup
  always_comb begin
    adc_x50  = MUL_W'(adc) * MUL_W'(50);
    prod     = PROD_W'(rref) * PROD_W'(adc);
    slot_nxt.rem = '0;
    slot_nxt.acc = {prod, {(FRAC_BITS + 1){1'b0}}};
    slot_nxt.den = ADC_BITS'(ADC_FS) - adc;
    priority if (adc_x50 > HIGH_LIM) slot_nxt.status = ST_HIGH;
    else if (adc_x50 < LOW_LIM)      slot_nxt.status = ST_LOW;
    else                             slot_nxt.status = ST_OK;
    // a zero reference gives zero, without offset
    slot_nxt.offset = (range0 && (rref != '0)) ? band_ofs : '0;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      slot_r <= slot_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_slot  = slot_r;

endmodule

### rtl/adcr_div_cell.sv
module adcr_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  adcr_pkg::div_slot_t up_slot,
  output logic                dn_valid,
  input  logic                dn_ready,
  output adcr_pkg::div_slot_t dn_slot
);
  import adcr_pkg::*;

  logic                valid_r;
  div_slot_t           slot_r;
  div_slot_t           slot_nxt;
  logic [ADC_BITS:0]   trial;
  logic                fits;

  // One restoring-division step: bring in the next dividend bit
  always_comb begin
    trial = {up_slot.rem, up_slot.acc[DIVD_W-1]};
    fits  = trial >= {1'b0, up_slot.den};
    slot_nxt = up_slot;
    if (fits) begin
      slot_nxt.rem = ADC_BITS'(trial - {1'b0, up_slot.den});
    end else begin
      slot_nxt.rem = trial[ADC_BITS-1:0];
    end
    slot_nxt.acc = {up_slot.acc[DIVD_W-2:0], fits};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      slot_r <= slot_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_slot  = slot_r;

endmodule

### rtl/adcr_back.sv
module adcr_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  adcr_pkg::div_slot_t                up_slot,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic [adcr_pkg::STATUS_W-1:0]      dn_status,
  output logic signed [adcr_pkg::OUT_W-1:0]  dn_res
);
  import adcr_pkg::*;

  logic                     valid_r;
  logic [STATUS_W-1:0]      status_r;
  logic signed [OUT_W-1:0]  res_r;
  logic signed [OUT_W-1:0]  res_nxt;
  logic [DIVD_W:0]          q_inc;
  logic [QX_W-1:0]          q_rnd;
  logic [QX_W-1:0]          q_sat;
  logic [OFS_SH_W-1:0]      ofs_q;

  // Round the doubled quotient, saturate, subtract the band offset
  always_comb begin
    q_inc = {1'b0, up_slot.acc} + (DIVD_W + 1)'(1);
    q_rnd = QX_W'(q_inc[DIVD_W:1]);
    q_sat = (q_rnd > OUT_MAX) ? OUT_MAX : q_rnd;
    ofs_q = {up_slot.offset, {FRAC_BITS{1'b0}}};
    if (up_slot.status != ST_OK) begin
      res_nxt = '0;
    end else begin
      res_nxt = $signed(q_sat[OUT_W-1:0]) - $signed(OUT_W'(ofs_q));
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      status_r <= up_slot.status;
      res_r    <= res_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_status = status_r;
  assign dn_res    = res_r;

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adcr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 64;     // a bit over the pipeline depth
  localparam int STALL_CYCLES = 300;    // long enough to fill every stage
  localparam int IDLE_PCT     = 16;

  // Rail limits: first reading that converts, first reading flagged high
  localparam int LOW_FIRST_OK = ADC_FS / 50 + 1;
  localparam int HIGH_FIRST   = ADC_FS * 49 / 50 + 1;

  // Range-0 calibration bands: upper edge (exclusive) and offset in ohms
  localparam int BAND1_END = 2600;
  localparam int BAND2_END = 2700;
  localparam int BAND3_END = 3005;
  localparam int BAND4_END = 3050;
  localparam int BAND5_END = 3100;
  localparam int BAND1_OFS = 310;
  localparam int BAND2_OFS = 330;
  localparam int BAND3_OFS = 360;
  localparam int BAND4_OFS = 300;
  localparam int BAND5_OFS = 90;

  localparam logic [RANGE_W-1:0]   RANGE_CAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_REF3 + 3'd1;
  localparam logic [REF_W-1:0]     REF_FULL = '1;
  localparam longint RES_CEIL = (longint'(1) <<< (OUT_W - 1)) - 1;

  typedef struct {
    logic [ADC_BITS-1:0]     adc;
    status_t                 status;
    logic signed [OUT_W-1:0] ohms_q8;
  } reading_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REF_W-1:0]     cfg_data;
  logic                 sink_ready = 1'b0;

  adcr_in_if  in_ch();
  adcr_out_if out_ch();

  assign out_ch.ready = sink_ready;

  adc_to_resistance_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the register file
  logic [RANGE_W-1:0] active_range;
  logic [REF_W-1:0]   ref_ohms [NUM_RANGES];

  reading_result_t pending_results[$];
  reading_result_t want;
  int error_count   = 0;
  int cycle_count   = 0;
  bit steady        = 1'b0;   // no idling on either side
  bit stall_request = 1'b0;
  int stall_left    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected result of one reading under the current register settings
  function automatic reading_result_t convert_reading(input logic [ADC_BITS-1:0] adc);
    reading_result_t  r;
    longint unsigned  a;
    longint unsigned  rref;
    longint unsigned  den;
    longint unsigned  q;
    longint unsigned  offset;
    longint           ohms;
    a        = 64'(adc);
    rref     = 64'(ref_ohms[active_range]);
    r.adc    = adc;
    r.status = ST_OK;
    ohms     = 0;
    if (a * 50 > 64'(ADC_FS) * 49) begin
      r.status = ST_HIGH;
    end else if (a * 50 < 64'(ADC_FS)) begin
      r.status = ST_LOW;
    end else if (rref != 0) begin
      den = 64'(ADC_FS) - a;
      // round to nearest, ties up
      q = ((((rref * a) << FRAC_BITS) * 2) + den) / (den * 2);
      if (q > RES_CEIL) q = RES_CEIL;
      ohms = longint'(q);
      if (active_range == RANGE_CAL) begin
        if (adc < BAND1_END)      offset = BAND1_OFS;
        else if (adc < BAND2_END) offset = BAND2_OFS;
        else if (adc < BAND3_END) offset = BAND3_OFS;
        else if (adc < BAND4_END) offset = BAND4_OFS;
        else if (adc < BAND5_END) offset = BAND5_OFS;
        else                      offset = 0;
        ohms = ohms - longint'(offset << FRAC_BITS);
      end
      if (ohms > RES_CEIL) ohms = RES_CEIL;
    end
    r.ohms_q8 = ohms[OUT_W-1:0];
    return r;
  endfunction

  // Mostly convertible readings, with band edges, rails and full-scale noise mixed in
  function automatic logic [ADC_BITS-1:0] random_reading();
    int unsigned pick;
    int unsigned base;
    pick = $urandom_range(99);
    if (pick < 65) return ADC_BITS'($urandom_range(HIGH_FIRST - 1, LOW_FIRST_OK));
    if (pick < 80) begin
      case ($urandom_range(6))
        0:       base = LOW_FIRST_OK;
        1:       base = HIGH_FIRST;
        2:       base = BAND1_END;
        3:       base = BAND2_END;
        4:       base = BAND3_END;
        5:       base = BAND4_END;
        default: base = BAND5_END;
      endcase
      return ADC_BITS'(base - 2 + $urandom_range(3));
    end
    if (pick < 90) return ADC_BITS'($urandom_range(ADC_FS));
    if ($urandom_range(1) == 0) return ADC_BITS'($urandom_range(LOW_FIRST_OK - 1));
    return ADC_BITS'($urandom_range(ADC_FS, HIGH_FIRST));
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Offer one reading and wait for it to be taken; valid stays up afterwards
  task automatic send_reading(input logic [ADC_BITS-1:0] adc);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.adc_value <= adc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(convert_reading(adc));
  endtask

  // Stop offering and let every reading in flight come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_we after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_RANGE) active_range = value[RANGE_W-1:0];
    else if (idx <= CFG_REF3) ref_ohms[RANGE_W'(idx - CFG_REF0)] = value;
  endtask

  task automatic apply_setting(input logic [REF_W-1:0] range_word,
                               input logic [REF_W-1:0] r0, input logic [REF_W-1:0] r1,
                               input logic [REF_W-1:0] r2, input logic [REF_W-1:0] r3,
                               input bit junk_write);
    wait_idle();
    write_reg(CFG_REF0, r0);
    write_reg(CFG_REF1, r1);
    write_reg(CFG_REF2, r2);
    write_reg(CFG_REF3, r3);
    write_reg(CFG_RANGE, range_word);
    // unused index: must leave every register alone
    if (junk_write) write_reg(CFG_IDX_W'(CFG_FIRST_UNUSED + $urandom_range(2)), REF_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Rails, calibration band edges and bit patterns at reset settings
  task automatic test_rail_and_band_edges();
    send_reading('0);
    send_reading(ADC_BITS'(1));
    send_reading(ADC_BITS'(LOW_FIRST_OK - 1));
    send_reading(ADC_BITS'(LOW_FIRST_OK));
    send_reading(ADC_BITS'(BAND1_END - 1));
    send_reading(ADC_BITS'(BAND1_END));
    send_reading(ADC_BITS'(BAND2_END - 1));
    send_reading(ADC_BITS'(BAND2_END));
    send_reading(ADC_BITS'(BAND3_END - 1));
    send_reading(ADC_BITS'(BAND3_END));
    send_reading(ADC_BITS'(BAND4_END - 1));
    send_reading(ADC_BITS'(BAND4_END));
    send_reading(ADC_BITS'(BAND5_END - 1));
    send_reading(ADC_BITS'(BAND5_END));
    send_reading(ADC_BITS'(HIGH_FIRST - 1));
    send_reading(ADC_BITS'(HIGH_FIRST));
    send_reading(ADC_BITS'(ADC_FS));
    send_reading(12'hAAA);
    send_reading(12'h555);
  endtask

  task automatic test_register_extremes();
    // range word with upper bits set selects range 3; reference above nominal top
    apply_setting(REF_FULL, REF0_RST, REF1_RST, REF2_RST, REF_FULL, 1'b0);
    send_reading(ADC_BITS'(LOW_FIRST_OK));
    send_reading(12'h800);
    send_reading(ADC_BITS'(HIGH_FIRST - 1));
    // zero reference in the calibrated range: result zero, no offset
    apply_setting(REF_W'(RANGE_CAL), '0, REF_FULL, REF_FULL, REF_FULL, 1'b0);
    send_reading(ADC_BITS'(LOW_FIRST_OK));
    send_reading(12'h800);
    send_reading(ADC_BITS'(ADC_FS));
    // stray writes to unused indexes
    apply_setting(REF_W'(RANGE_CAL), REF0_RST, REF1_RST, REF2_RST, REF3_RST, 1'b1);
    send_reading(12'h800);
    send_reading(ADC_BITS'(BAND5_END));
  endtask

  // Several register settings, each range in turn, with random readings
  task automatic test_random_settings();
    logic [REF_W-1:0] refs [NUM_RANGES];
    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < NUM_RANGES; r++) begin
        case ($urandom_range(7))
          0:       refs[r] = '0;
          1:       refs[r] = REF_FULL;
          2:       refs[r] = REF_W'($urandom_range(1000));
          default: refs[r] = REF_W'($urandom_range(1000000));
        endcase
      end
      apply_setting({(REF_W - RANGE_W)'($urandom), RANGE_W'(phase)},
                    refs[0], refs[1], refs[2], refs[3], $urandom_range(1) == 1);
      repeat (35) send_reading(random_reading());
    end
  endtask

  // Back-to-back items with no idling on either side
  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (60) send_reading(random_reading());
    wait_idle();
    steady = 1'b0;
  endtask

  // Receiver holds off long enough that the pipeline fills and input stalls
  task automatic test_output_backpressure();
    stall_request = 1'b1;
    repeat (90) send_reading(random_reading());
  endtask

  // Result sink: random ready, with a long hold-off on request
  always @(posedge clk) begin
    if (stall_request) begin
      stall_left    = STALL_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d ohms_q8 %0d",
                                  out_ch.status, out_ch.resistance_q8));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("adc %0d range %0d: status %0d, expected %0d",
                                    want.adc, active_range, out_ch.status, want.status));
        if (out_ch.resistance_q8 !== want.ohms_q8)
          report_mismatch($sformatf("adc %0d range %0d: ohms_q8 %0d, expected %0d",
                                    want.adc, active_range, out_ch.resistance_q8,
                                    want.ohms_q8));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.adc_value <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_RANGE;
    cfg_data        <= '0;
    rst_n           <= 1'b0;
    active_range = RANGE_CAL;
    ref_ohms[0]  = REF0_RST;
    ref_ohms[1]  = REF1_RST;
    ref_ohms[2]  = REF2_RST;
    ref_ohms[3]  = REF3_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_rail_and_band_edges();
    test_register_extremes();
    test_random_settings();
    test_steady_stream();
    test_output_backpressure();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
